// ===== src/rqfbi_pkg.sv =====
// rqfbi_pkg: shared types and constants for the ring queue with front insert
// command and result beat layouts, operation codes, default sizes
// no dependencies
`default_nettype none

package rqfbi_pkg;

	localparam int RQFBI_DEPTH     = 16;
	localparam int RQFBI_ITEM_BITS = 32;
	localparam int KIND_W          = 3;
	localparam int DATA_W          = 32;
	localparam int CAP_W           = 5;

	localparam logic [KIND_W-1:0] KIND_SEND_BACK  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SEND_FRONT = 3'd1;
	localparam logic [KIND_W-1:0] KIND_RECEIVE    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_PEEK       = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DROP_FRONT = 3'd4;
	localparam logic [KIND_W-1:0] KIND_FLUSH      = 3'd5;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [DATA_W-1:0] item_data;
	} rqfbi_cmd_t;

	typedef struct packed {
		logic              accepted;
		logic [DATA_W-1:0] out_data;
		logic [CAP_W-1:0]  items_held;
		logic [CAP_W-1:0]  slots_free;
		logic              is_empty;
		logic              is_full;
	} rqfbi_res_t;

endpackage

`default_nettype wire

// ===== src/ring_queue_front_back_insert.sv =====
// ring_queue_front_back_insert: circular item queue with back append and front insert
// slots held in one synchronous memory, indexes and count in flops
// depends on rqfbi_pkg
// the result strobe comes in the cycle after the command beat; read data comes straight from memory
// throughput: one command per cycle while busy is low; busy is high only while a config beat is offered
// config write empties the queue; a config beat is taken only when no result is pending
// reset: queue empty, capacity min(DEPTH, 16); slot memory is not cleared, no clearing pass
`default_nettype none

module ring_queue_front_back_insert #(
	parameter int DEPTH     = rqfbi_pkg::RQFBI_DEPTH,
	parameter int ITEM_BITS = rqfbi_pkg::RQFBI_ITEM_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire rqfbi_pkg::rqfbi_cmd_t         cmd,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [rqfbi_pkg::CAP_W-1:0]   cfg_data,
	output logic                               done,
	output rqfbi_pkg::rqfbi_res_t              result
);
	import rqfbi_pkg::*;

	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMP_W   = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;
	localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;
	localparam int CAP_RST = (DEPTH < 16) ? DEPTH : 16;

	function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] idx,
			input logic [CAP_W-1:0] cap);
		logic [CMP_W-1:0] nxt;
		nxt = CMP_W'(idx) + CMP_W'(1);
		return (nxt >= CMP_W'(cap)) ? '0 : nxt[IDX_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] idx,
			input logic [CAP_W-1:0] cap);
		return (idx == '0) ? IDX_W'(cap - CAP_W'(1)) : idx - IDX_W'(1);
	endfunction

	logic [ITEM_BITS-1:0] mem [DEPTH];
	logic [ITEM_BITS-1:0] rd_data_q;

	logic [CAP_W-1:0] cap_q;
	logic [IDX_W-1:0] wr_idx_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic [CAP_W-1:0] cnt_q;

	logic             fire;
	logic             cfg_fire;
	logic [CAP_W-1:0] cap_sat;
	logic [IDX_W-1:0] wr_idx_d;
	logic [IDX_W-1:0] rd_idx_d;
	logic [CAP_W-1:0] cnt_d;
	logic             acc_d;
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	logic             mem_re;
	logic [IDX_W-1:0] mem_ra;
	logic             not_full;
	logic             not_empty;

	logic             valid_s1;
	logic             acc_s1;
	logic             rd_s1;
	logic [CAP_W-1:0] held_s1;
	logic [CAP_W-1:0] free_s1;
	logic             empty_s1;
	logic             full_s1;

	assign busy      = cfg_valid;
	assign cfg_ready = ~valid_s1;
	assign fire      = start & ~busy;
	assign cfg_fire  = cfg_valid & cfg_ready;

	always_comb begin
		if (cfg_data == '0) begin
			cap_sat = CAP_W'(1);
		end else if (cfg_data > CAP_W'(CAP_MAX)) begin
			cap_sat = CAP_W'(CAP_MAX);
		end else begin
			cap_sat = cfg_data;
		end
	end

	assign not_full  = cnt_q < cap_q;
	assign not_empty = cnt_q != '0;

	always_comb begin
		wr_idx_d = wr_idx_q;
		rd_idx_d = rd_idx_q;
		cnt_d    = cnt_q;
		acc_d    = 1'b0;
		mem_we   = 1'b0;
		mem_wa   = wr_idx_q;
		mem_re   = 1'b0;
		mem_ra   = step_up(rd_idx_q, cap_q);
		case (cmd.kind)
			KIND_SEND_BACK: begin
				if (not_full) begin
					mem_we   = 1'b1;
					mem_wa   = wr_idx_q;
					wr_idx_d = step_up(wr_idx_q, cap_q);
					cnt_d    = cnt_q + CAP_W'(1);
					acc_d    = 1'b1;
				end
			end
			KIND_SEND_FRONT: begin
				if (not_full) begin
					mem_we   = 1'b1;
					mem_wa   = rd_idx_q;
					rd_idx_d = step_down(rd_idx_q, cap_q);
					cnt_d    = cnt_q + CAP_W'(1);
					acc_d    = 1'b1;
				end
			end
			KIND_RECEIVE: begin
				if (not_empty) begin
					mem_re   = 1'b1;
					rd_idx_d = mem_ra;
					cnt_d    = cnt_q - CAP_W'(1);
					acc_d    = 1'b1;
				end
			end
			KIND_PEEK: begin
				if (not_empty) begin
					mem_re = 1'b1;
					acc_d  = 1'b1;
				end
			end
			KIND_DROP_FRONT: begin
				if (not_empty) begin
					rd_idx_d = mem_ra;
					cnt_d    = cnt_q - CAP_W'(1);
					acc_d    = 1'b1;
				end
			end
			KIND_FLUSH: begin
				wr_idx_d = '0;
				rd_idx_d = IDX_W'(cap_q - CAP_W'(1));
				cnt_d    = '0;
				acc_d    = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// slot memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (fire && mem_we) begin
			mem[mem_wa] <= ITEM_BITS'(cmd.item_data);
		end
		if (fire && mem_re) begin
			rd_data_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CAP_W'(CAP_RST);
			wr_idx_q <= '0;
			rd_idx_q <= IDX_W'(CAP_RST - 1);
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= fire;
			if (cfg_fire) begin
				cap_q    <= cap_sat;
				wr_idx_q <= '0;
				rd_idx_q <= IDX_W'(cap_sat - CAP_W'(1));
				cnt_q    <= '0;
			end else if (fire) begin
				wr_idx_q <= wr_idx_d;
				rd_idx_q <= rd_idx_d;
				cnt_q    <= cnt_d;
			end
		end
	end

	// result beat fields
	always_ff @(posedge clk) begin
		if (fire) begin
			acc_s1   <= acc_d;
			rd_s1    <= mem_re;
			held_s1  <= cnt_d;
			free_s1  <= cap_q - cnt_d;
			empty_s1 <= cnt_d == '0;
			full_s1  <= cnt_d == cap_q;
		end
	end

	assign done = valid_s1;

	always_comb begin
		result            = '0;
		result.accepted   = acc_s1;
		result.out_data   = rd_s1 ? DATA_W'(rd_data_q) : '0;
		result.items_held = held_s1;
		result.slots_free = free_s1;
		result.is_empty   = empty_s1;
		result.is_full    = full_s1;
	end

`ifndef SYNTH
	a_cnt_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cap_q)
		else $error("item count above capacity");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(wr_idx_q) < CMP_W'(cap_q) && CMP_W'(rd_idx_q) < CMP_W'(cap_q))
		else $error("queue index outside capacity");

	a_beat_follows: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> done)
		else $error("command beat without result strobe");

	a_cfg_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_fire |=> cnt_q == '0 && wr_idx_q == '0)
		else $error("config write did not empty the queue");

	a_status_sum: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.items_held + result.slots_free) == cap_q)
		else $error("held plus free differs from capacity");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_ring_queue_front_back_insert.sv =====
`timescale 1ns / 1ps
// tb_ring_queue_front_back_insert: self-checking bench for the ring queue with front insert
// directed table then random command bursts across capacity settings, scored by a queue model
// depends on rqfbi_pkg and ring_queue_front_back_insert

module tb_ring_queue_front_back_insert;
	import rqfbi_pkg::*;

	localparam int SLOT_W = $clog2(RQFBI_DEPTH);
	localparam logic [KIND_W-1:0] KIND_BAD_LO = 3'd6;
	localparam logic [KIND_W-1:0] KIND_BAD_HI = 3'd7;
	localparam rqfbi_res_t IDLE_EMPTY = {1'b0, 32'h0, 5'd0, 5'd16, 1'b1, 1'b0};

	typedef struct {
		bit         typed;
		rqfbi_res_t want;
	} op_tag_t;

	typedef struct {
		bit                is_cfg;
		logic [KIND_W-1:0] kind;
		logic [DATA_W-1:0] data;
		bit                typed;
		rqfbi_res_t        want;
	} plan_row_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	rqfbi_cmd_t       cmd;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CAP_W-1:0] cfg_data;
	logic             done;
	rqfbi_res_t       result;

	ring_queue_front_back_insert u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

	// queue model
	logic [DATA_W-1:0] slot_img [RQFBI_DEPTH];
	int unsigned       wr_ptr;
	int unsigned       rd_ptr;
	int unsigned       held;
	int unsigned       cap;

	op_tag_t    typed_want [$];
	rqfbi_res_t due_status [$];
	plan_row_t  plan [$];
	int         mismatches = 0;
	int         burst_left = 0;

	function automatic int unsigned ring_next(int unsigned i);
		return (i + 1 >= cap) ? 0 : i + 1;
	endfunction

	function automatic int unsigned ring_prev(int unsigned i);
		return (i == 0) ? cap - 1 : i - 1;
	endfunction

	function automatic void clear_queue();
		wr_ptr = 0;
		rd_ptr = cap - 1;
		held   = 0;
	endfunction

	function automatic void set_capacity(logic [CAP_W-1:0] v);
		if (v == '0)
			cap = 1;
		else if (32'(v) > RQFBI_DEPTH)
			cap = RQFBI_DEPTH;
		else
			cap = 32'(v);
		clear_queue();
	endfunction

	function automatic rqfbi_res_t queue_op_outcome(rqfbi_cmd_t c);
		rqfbi_res_t        r;
		logic [SLOT_W-1:0] at;
		r = '0;
		case (c.kind)
			KIND_SEND_BACK: begin
				if (held < cap) begin
					at = SLOT_W'(wr_ptr);
					slot_img[at] = c.item_data;
					wr_ptr = ring_next(wr_ptr);
					held++;
					r.accepted = 1'b1;
				end
			end
			KIND_SEND_FRONT: begin
				if (held < cap) begin
					at = SLOT_W'(rd_ptr);
					slot_img[at] = c.item_data;
					rd_ptr = ring_prev(rd_ptr);
					held++;
					r.accepted = 1'b1;
				end
			end
			KIND_RECEIVE: begin
				if (held > 0) begin
					rd_ptr = ring_next(rd_ptr);
					at = SLOT_W'(rd_ptr);
					r.out_data = slot_img[at];
					held--;
					r.accepted = 1'b1;
				end
			end
			KIND_PEEK: begin
				if (held > 0) begin
					at = SLOT_W'(ring_next(rd_ptr));
					r.out_data = slot_img[at];
					r.accepted = 1'b1;
				end
			end
			KIND_DROP_FRONT: begin
				if (held > 0) begin
					rd_ptr = ring_next(rd_ptr);
					held--;
					r.accepted = 1'b1;
				end
			end
			KIND_FLUSH: begin
				clear_queue();
				r.accepted = 1'b1;
			end
			default: begin
			end
		endcase
		r.items_held = CAP_W'(held);
		r.slots_free = CAP_W'(cap - held);
		r.is_empty   = (held == 0);
		r.is_full    = (held == cap);
		return r;
	endfunction

	function automatic void check_field(string name, logic [DATA_W-1:0] want,
			logic [DATA_W-1:0] got);
		if (want !== got) begin
			$display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void add_row(bit is_cfg, logic [KIND_W-1:0] kind,
			logic [DATA_W-1:0] data, bit typed, rqfbi_res_t want);
		plan_row_t r;
		r.is_cfg = is_cfg;
		r.kind   = kind;
		r.data   = data;
		r.typed  = typed;
		r.want   = want;
		plan.push_back(r);
	endfunction

	function automatic logic [KIND_W-1:0] pick_kind(bit filling);
		int r;
		r = $urandom_range(0, 99);
		if (filling) begin
			if (r < 35) return KIND_SEND_BACK;
			if (r < 65) return KIND_SEND_FRONT;
			if (r < 77) return KIND_RECEIVE;
			if (r < 85) return KIND_PEEK;
			if (r < 93) return KIND_DROP_FRONT;
			if (r < 95) return KIND_FLUSH;
		end else begin
			if (r < 15) return KIND_SEND_BACK;
			if (r < 27) return KIND_SEND_FRONT;
			if (r < 57) return KIND_RECEIVE;
			if (r < 72) return KIND_PEEK;
			if (r < 92) return KIND_DROP_FRONT;
			if (r < 95) return KIND_FLUSH;
		end
		return (r[0]) ? KIND_BAD_HI : KIND_BAD_LO;
	endfunction

	function automatic logic [DATA_W-1:0] pick_word();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// scoreboard
	always @(posedge clk) begin : monitor
		rqfbi_res_t want;
		rqfbi_res_t pred;
		op_tag_t    tag;
		if (arst_n) begin
			if (done) begin
				if (due_status.size() == 0) begin
					$display("%0t result beat with nothing expected: actual %h", $time, result);
					mismatches++;
				end else begin
					want = due_status.pop_front();
					check_field("accepted", DATA_W'(want.accepted),
						DATA_W'(result.accepted));
					check_field("out_data", want.out_data, result.out_data);
					check_field("items_held", DATA_W'(want.items_held),
						DATA_W'(result.items_held));
					check_field("slots_free", DATA_W'(want.slots_free),
						DATA_W'(result.slots_free));
					check_field("is_empty", DATA_W'(want.is_empty),
						DATA_W'(result.is_empty));
					check_field("is_full", DATA_W'(want.is_full),
						DATA_W'(result.is_full));
				end
			end
			if (cfg_valid && cfg_ready)
				set_capacity(cfg_data);
			if (start && !busy) begin
				pred = queue_op_outcome(cmd);
				tag  = typed_want.pop_front();
				due_status.push_back(tag.typed ? tag.want : pred);
			end
		end
	end

	task automatic drive_op(rqfbi_cmd_t c, bit typed, rqfbi_res_t want);
		op_tag_t tag;
		tag.typed = typed;
		tag.want  = want;
		typed_want.push_back(tag);
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
	endtask

	task automatic sender_gap(bit steady);
		if (!steady) begin
			if (burst_left == 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = $urandom_range(1, 24);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (due_status.size() != 0) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] v);
		drain();
		repeat (2) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		rqfbi_cmd_t       c;
		logic [CAP_W-1:0] cap_v;
		bit               filling;
		int               flip_in;
		arst_n    = 1'b0;
		start     = 1'b0;
		cmd       = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		set_capacity(CAP_W'(RQFBI_DEPTH));

		add_row(1'b0, KIND_PEEK, 32'h0, 1'b1, IDLE_EMPTY);
		add_row(1'b0, KIND_RECEIVE, 32'h0, 1'b1, IDLE_EMPTY);
		add_row(1'b0, KIND_DROP_FRONT, 32'h0, 1'b1, IDLE_EMPTY);
		add_row(1'b0, KIND_BAD_LO, 32'hFFFF_FFFF, 1'b1, IDLE_EMPTY);
		add_row(1'b0, KIND_BAD_HI, 32'h0, 1'b1, IDLE_EMPTY);
		add_row(1'b0, KIND_SEND_BACK, 32'hFFFF_FFFF, 1'b1,
			{1'b1, 32'h0, 5'd1, 5'd15, 1'b0, 1'b0});
		add_row(1'b0, KIND_SEND_FRONT, 32'h0, 1'b1, {1'b1, 32'h0, 5'd2, 5'd14, 1'b0, 1'b0});
		add_row(1'b0, KIND_PEEK, 32'h0, 1'b1, {1'b1, 32'h0, 5'd2, 5'd14, 1'b0, 1'b0});
		add_row(1'b0, KIND_RECEIVE, 32'h0, 1'b1, {1'b1, 32'h0, 5'd1, 5'd15, 1'b0, 1'b0});
		add_row(1'b0, KIND_PEEK, 32'h0, 1'b1,
			{1'b1, 32'hFFFF_FFFF, 5'd1, 5'd15, 1'b0, 1'b0});
		add_row(1'b0, KIND_SEND_FRONT, 32'hA5A5_A5A5, 1'b0, '0);
		add_row(1'b0, KIND_DROP_FRONT, 32'h0, 1'b0, '0);
		add_row(1'b0, KIND_FLUSH, 32'h0, 1'b1, {1'b1, 32'h0, 5'd0, 5'd16, 1'b1, 1'b0});
		add_row(1'b1, KIND_FLUSH, 32'd1, 1'b0, '0);
		add_row(1'b0, KIND_SEND_FRONT, 32'h1234_5678, 1'b1,
			{1'b1, 32'h0, 5'd1, 5'd0, 1'b0, 1'b1});
		add_row(1'b0, KIND_SEND_BACK, 32'h1, 1'b1, {1'b0, 32'h0, 5'd1, 5'd0, 1'b0, 1'b1});
		add_row(1'b0, KIND_SEND_FRONT, 32'h2, 1'b1, {1'b0, 32'h0, 5'd1, 5'd0, 1'b0, 1'b1});
		add_row(1'b0, KIND_RECEIVE, 32'h0, 1'b1,
			{1'b1, 32'h1234_5678, 5'd0, 5'd1, 1'b1, 1'b0});
		add_row(1'b1, KIND_FLUSH, 32'd0, 1'b0, '0);
		add_row(1'b0, KIND_SEND_BACK, 32'h5A5A_5A5A, 1'b0, '0);
		add_row(1'b0, KIND_PEEK, 32'h0, 1'b0, '0);
		add_row(1'b0, KIND_DROP_FRONT, 32'h0, 1'b0, '0);
		add_row(1'b1, KIND_FLUSH, 32'd31, 1'b0, '0);
		add_row(1'b0, KIND_SEND_BACK, 32'h8000_0001, 1'b0, '0);
		add_row(1'b0, KIND_FLUSH, 32'h0, 1'b0, '0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				write_capacity(plan[i].data[CAP_W-1:0]);
			end else begin
				c.kind      = plan[i].kind;
				c.item_data = plan[i].data;
				drive_op(c, plan[i].typed, plan[i].want);
				sender_gap(1'b0);
			end
		end

		filling = 1'b1;
		flip_in = 20;
		for (int p = 0; p < 7; p++) begin
			case (p)
				0:       cap_v = 5'd2;
				1:       cap_v = 5'd16;
				2:       cap_v = 5'd1;
				3:       cap_v = 5'd0;
				4:       cap_v = CAP_W'($urandom_range(17, 31));
				default: cap_v = CAP_W'($urandom_range(3, 15));
			endcase
			write_capacity(cap_v);
			for (int i = 0; i < 128; i++) begin
				if (flip_in == 0) begin
					filling = !filling;
					flip_in = $urandom_range(10, 60);
				end else begin
					flip_in--;
				end
				c.kind      = pick_kind(filling);
				c.item_data = pick_word();
				drive_op(c, 1'b0, '0);
				if ($urandom_range(0, 63) == 0)
					drain();
				else
					sender_gap(p == 1);
			end
		end

		drain();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && due_status.size() == 0) begin
			$display("PASS ring_queue_front_back_insert");
		end else begin
			$display("FAIL ring_queue_front_back_insert");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL ring_queue_front_back_insert");
		$finish;
	end

endmodule
